/* src/acr_pkg.sv */
package acr_pkg;

  localparam logic       OP_RESOLVE = 1'b0;
  localparam logic       OP_ADD     = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [1:0] REG_SUBNET_MASK     = 2'd0;
  localparam logic [1:0] REG_NETWORK_ADDRESS = 2'd1;
  localparam logic [1:0] REG_GATEWAY_ADDRESS = 2'd2;

  localparam logic [1:0] KIND_FREE = 2'd0;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [1:0]  kind;
    logic [7:0]  count;
  } acr_entry_t;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [47:0] mac;
    logic [1:0]  kind;
  } acr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic [31:0] hop;
    logic [5:0]  slot;
  } acr_result_t;

endpackage

/* src/arp_cache_resolver_unit.sv */
// IPv4-to-MAC address cache with TABLE_ENTRIES slots held in one RAM.
// Input channel (in_valid/in_stall): opcode 0 resolves ip_address through
// the subnet mask, network address and gateway registers to a next hop and
// looks it up; opcode 1 adds or updates the entry for ip_address with
// mac_address and entry_kind. Each transfer yields exactly one result on the
// output channel (out_valid/out_stall): status, resolved_mac, next_hop_ip
// and slot_index.
// The table is scanned one slot per cycle through the registered RAM read
// port, and the scan stops at the first matching slot; then a commit state
// writes back the hit entry with its count raised, or the new entry of an
// add. One item is in work at a time: a new transfer is taken only once the
// last result has left the engine.
// A finished result waits in the output register, and the next item is
// taken while it waits; a stalled receiver holds the engine once a second
// result is ready.
// Reset clears the config registers and marks every slot as cleared (IP 0,
// MAC 0, free, count 0) through per-slot valid bits; no sweep. The user must
// write configuration over the APB port while idle; the block does not check.
module arp_cache_resolver_unit #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] ip_address,
  input  logic [47:0] mac_address,
  input  logic [1:0]  entry_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [47:0] resolved_mac,
  output logic [31:0] next_hop_ip,
  output logic [5:0]  slot_index
);

  logic [31:0] subnet_mask;
  logic [31:0] network_address;
  logic [31:0] gateway_address;

  logic                 cfg_write;
  logic                 engine_idle;
  logic                 in_take;
  acr_pkg::acr_req_t    req;
  logic                 res_valid;
  acr_pkg::acr_result_t res;
  logic                 res_take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_mask     <= '0;
      network_address <= '0;
      gateway_address <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        acr_pkg::REG_SUBNET_MASK:     subnet_mask     <= pwdata;
        acr_pkg::REG_NETWORK_ADDRESS: network_address <= pwdata;
        acr_pkg::REG_GATEWAY_ADDRESS: gateway_address <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      acr_pkg::REG_SUBNET_MASK:     prdata = subnet_mask;
      acr_pkg::REG_NETWORK_ADDRESS: prdata = network_address;
      acr_pkg::REG_GATEWAY_ADDRESS: prdata = gateway_address;
      default:                      prdata = '0;
    endcase
  end

  assign in_stall = !engine_idle;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    req.op   = opcode;
    req.mac  = mac_address;
    req.kind = entry_kind;
    if ((opcode == acr_pkg::OP_RESOLVE) &&
        ((ip_address & subnet_mask) != network_address)) begin
      req.key = gateway_address;
    end else begin
      req.key = ip_address;
    end
  end

  acr_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_take),
    .req_in   (req),
    .idle     (engine_idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status       <= res.status;
      resolved_mac <= res.mac;
      next_hop_ip  <= res.hop;
      slot_index   <= res.slot;
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("engine took a transfer without going busy");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == acr_pkg::STATUS_MISS)) |->
      ((resolved_mac == 48'd0) && (slot_index == 6'd0)))
    else $error("miss result carries a MAC or slot");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == acr_pkg::STATUS_FULL)) |->
      ((resolved_mac == 48'd0) && (slot_index == 6'd0)))
    else $error("table full result carries a MAC or slot");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(slot_index) < 32'(TABLE_ENTRIES)))
    else $error("slot index beyond table");

endmodule

/* src/acr_ram.sv */
module acr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/acr_engine.sv */
module acr_engine #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  acr_pkg::acr_req_t    req_in,
  output logic                 idle,
  output logic                 res_valid,
  output acr_pkg::acr_result_t res,
  input  logic                 res_take
);

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);
  localparam logic [CNTW-1:0] NUM_ENTRIES = CNTW'(TABLE_ENTRIES);
  localparam int EW = $bits(acr_pkg::acr_entry_t);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t               state;
  acr_pkg::acr_req_t    req;
  logic [CNTW-1:0]      issue_cnt;
  logic                 rd_pend;
  logic [IDXW-1:0]      rd_idx;
  logic                 rd_ent_vld;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic                 found;
  logic                 free_found;
  logic [IDXW-1:0]      hit_idx;
  logic [IDXW-1:0]      free_idx;
  acr_pkg::acr_entry_t  hit;
  acr_pkg::acr_result_t result;
  acr_pkg::acr_result_t result_next;

  logic                 issue;
  logic [IDXW-1:0]      rd_addr;
  logic [EW-1:0]        rd_data;
  acr_pkg::acr_entry_t  entry;
  logic                 match;
  logic                 wr_en;
  logic [IDXW-1:0]      wr_addr;
  acr_pkg::acr_entry_t  wr_data;

  assign issue   = (state == S_SCAN) && (issue_cnt < NUM_ENTRIES);
  assign rd_addr = issue_cnt[IDXW-1:0];
  assign entry   = rd_ent_vld ? acr_pkg::acr_entry_t'(rd_data) : '0;
  assign match   = rd_pend && (entry.ip == req.key);

  always_comb begin
    wr_addr = found ? hit_idx : free_idx;
    wr_en   = (state == S_COMMIT) &&
              (found || ((req.op == acr_pkg::OP_ADD) && free_found));
    if (req.op == acr_pkg::OP_RESOLVE) begin
      wr_data.ip    = hit.ip;
      wr_data.mac   = hit.mac;
      wr_data.kind  = hit.kind;
      wr_data.count = (hit.count == acr_pkg::COUNT_MAX) ? hit.count : 8'(hit.count + 8'd1);
    end else begin
      wr_data.ip    = req.key;
      wr_data.mac   = req.mac;
      wr_data.kind  = req.kind;
      wr_data.count = '0;
    end
  end

  always_comb begin
    result_next.hop = req.key;
    result_next.mac = '0;
    result_next.slot = '0;
    if (found) begin
      result_next.status = acr_pkg::STATUS_OK;
      result_next.slot   = 6'(hit_idx);
      if (req.op == acr_pkg::OP_RESOLVE) begin
        result_next.mac = hit.mac;
      end
    end else if (req.op == acr_pkg::OP_RESOLVE) begin
      result_next.status = acr_pkg::STATUS_MISS;
    end else if (free_found) begin
      result_next.status = acr_pkg::STATUS_OK;
      result_next.slot   = 6'(free_idx);
    end else begin
      result_next.status = acr_pkg::STATUS_FULL;
    end
  end

  acr_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(EW'(wr_data)),
    .rd_en  (issue),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend    <= issue;
      rd_idx     <= rd_addr;
      rd_ent_vld <= entry_valid[rd_addr];
      if (issue) begin
        issue_cnt <= CNTW'(issue_cnt + 1'b1);
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req        <= req_in;
            issue_cnt  <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (match) begin
              found   <= 1'b1;
              hit_idx <= rd_idx;
              hit     <= entry;
              state   <= S_COMMIT;
            end else begin
              if (entry.kind == acr_pkg::KIND_FREE) begin
                free_found <= 1'b1;
                free_idx   <= rd_idx;
              end
              if (rd_idx == LAST_IDX) begin
                state <= S_COMMIT;
              end
            end
          end
        end
        S_COMMIT: begin
          result <= result_next;
          state  <= S_RESULT;
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res       = result;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_ENTRIES = 8;
  localparam int POOL_SIZE = 12;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int REPORT_LIMIT = 100;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    acr_pkg::acr_req_t req;
    bit                drain;
  } pending_req_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [47:0] resolved_mac;
  logic [31:0] next_hop_ip;
  logic [5:0]  slot_index;

  acr_pkg::acr_req_t cur_req = '0;
  logic              in_done = 1'b0;

  pending_req_t         request_q[$];
  acr_pkg::acr_result_t outcome_q[$];
  acr_pkg::acr_result_t want_res;
  int                   mismatch_count = 0;

  logic [31:0] cfg_mask = '0;
  logic [31:0] cfg_network = '0;
  logic [31:0] cfg_gateway = '0;
  logic [31:0] tbl_ip    [TABLE_ENTRIES];
  logic [47:0] tbl_mac   [TABLE_ENTRIES];
  logic [1:0]  tbl_kind  [TABLE_ENTRIES];
  logic [7:0]  tbl_count [TABLE_ENTRIES];
  logic [31:0] ip_pool   [POOL_SIZE];

  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  logic [2:0] stall_tick = '0;
  int gap_left = 0;
  int burst_left = 0;

  arp_cache_resolver_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (cur_req.op),
    .ip_address  (cur_req.key),
    .mac_address (cur_req.mac),
    .entry_kind  (cur_req.kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .resolved_mac(resolved_mac),
    .next_hop_ip (next_hop_ip),
    .slot_index  (slot_index)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic acr_pkg::acr_result_t arp_outcome(acr_pkg::acr_req_t req);
    acr_pkg::acr_result_t res;
    int free_slot;
    bit found;
    res = '0;
    res.status = acr_pkg::STATUS_OK;
    res.hop = req.key;
    found = 1'b0;
    free_slot = -1;
    if (req.op == acr_pkg::OP_RESOLVE) begin
      if ((req.key & cfg_mask) != cfg_network) res.hop = cfg_gateway;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (!found && tbl_ip[k] == res.hop) begin
          found = 1'b1;
          if (tbl_count[k] != acr_pkg::COUNT_MAX) tbl_count[k] = tbl_count[k] + 8'd1;
          res.mac = tbl_mac[k];
          res.slot = 6'(k);
        end
      end
      if (!found) res.status = acr_pkg::STATUS_MISS;
    end else begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (!found) begin
          if (tbl_ip[k] == req.key) begin
            found = 1'b1;
            tbl_mac[k] = req.mac;
            tbl_kind[k] = req.kind;
            tbl_count[k] = '0;
            res.slot = 6'(k);
          end else if (tbl_kind[k] == acr_pkg::KIND_FREE) begin
            free_slot = k;
          end
        end
      end
      if (!found) begin
        if (free_slot >= 0) begin
          tbl_ip[free_slot] = req.key;
          tbl_mac[free_slot] = req.mac;
          tbl_kind[free_slot] = req.kind;
          tbl_count[free_slot] = '0;
          res.slot = 6'(free_slot);
        end else begin
          res.status = acr_pkg::STATUS_FULL;
        end
      end
    end
    return res;
  endfunction

  function automatic acr_pkg::acr_req_t random_req();
    acr_pkg::acr_req_t req;
    req.op = $urandom_range(0, 1) ? acr_pkg::OP_ADD : acr_pkg::OP_RESOLVE;
    case ($urandom_range(0, 11))
      0: req.key = 32'h0000_0000;
      1: req.key = 32'hFFFF_FFFF;
      2: req.key = cfg_gateway;
      3: req.key = cfg_network | ($urandom & ~cfg_mask);
      4: req.key = $urandom;
      5, 6: req.key = tbl_ip[$urandom_range(0, TABLE_ENTRIES - 1)];
      default: req.key = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endcase
    case ($urandom_range(0, 7))
      0: req.mac = '0;
      1: req.mac = '1;
      default: req.mac = {16'($urandom), $urandom};
    endcase
    req.kind = 2'($urandom_range(0, 3));
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_req(input logic op, input logic [31:0] ip, input logic [47:0] mac,
                          input logic [1:0] kind);
    pending_req_t item;
    item.req.op = op;
    item.req.key = ip;
    item.req.mac = mac;
    item.req.kind = kind;
    item.drain = 1'b0;
    request_q.push_back(item);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      acr_pkg::REG_SUBNET_MASK:     cfg_mask = value;
      acr_pkg::REG_NETWORK_ADDRESS: cfg_network = value;
      acr_pkg::REG_GATEWAY_ADDRESS: cfg_gateway = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] mask, input logic [31:0] net,
                           input logic [31:0] gw);
    wait_idle();
    apb_write(acr_pkg::REG_SUBNET_MASK, mask);
    apb_write(acr_pkg::REG_NETWORK_ADDRESS, net);
    apb_write(acr_pkg::REG_GATEWAY_ADDRESS, gw);
  endtask

  task automatic random_phase(input logic [31:0] mask, input logic [31:0] net,
                              input logic [31:0] gw, input int count, input bit long_hold);
    pending_req_t item;
    configure(mask, net, gw);
    for (int i = 0; i < POOL_SIZE; i++)
      ip_pool[i] = (i < POOL_SIZE / 2) ? (net | ($urandom & ~mask)) : $urandom;
    for (int n = 0; n < count; n++) begin
      item.req = random_req();
      item.drain = (n == count / 2) || ($urandom_range(0, 49) == 0);
      request_q.push_back(item);
    end
    if (long_hold) hold_requests++;
  endtask

  task automatic random_prefix_phase(input int count, input bit long_hold);
    logic [31:0] mask;
    logic [31:0] net;
    mask = 32'hFFFF_FFFF << (32 - $urandom_range(8, 30));
    net = $urandom & mask;
    random_phase(mask, net, net | ($urandom & ~mask), count, long_hold);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain && outcome_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_req <= request_q[0].req;
        request_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= in_valid && !in_stall;
      if (in_valid && !in_stall) outcome_q.push_back(arp_outcome(cur_req));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      holds_served <= hold_requests;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= stall_tick[2];
      endcase
      stall_tick <= stall_tick + 3'd1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result transfer with nothing expected, status %0d", status));
      end else begin
        want_res = outcome_q.pop_front();
        if (status !== want_res.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want_res.status));
        if (resolved_mac !== want_res.mac)
          report_mismatch($sformatf("resolved_mac got %h want %h", resolved_mac, want_res.mac));
        if (next_hop_ip !== want_res.hop)
          report_mismatch($sformatf("next_hop_ip got %h want %h", next_hop_ip, want_res.hop));
        if (slot_index !== want_res.slot)
          report_mismatch($sformatf("slot_index got %0d want %0d", slot_index, want_res.slot));
      end
    end
  end

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_ip[k] = '0;
      tbl_mac[k] = '0;
      tbl_kind[k] = acr_pkg::KIND_FREE;
      tbl_count[k] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_req(acr_pkg::OP_RESOLVE, 32'h0000_0000, 48'h0, 2'd0);
    push_req(acr_pkg::OP_RESOLVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3);
    push_req(acr_pkg::OP_ADD,     32'h0000_0000, 48'hFFFF_FFFF_FFFF, 2'd0);
    push_req(acr_pkg::OP_RESOLVE, 32'h0000_0000, 48'h0, 2'd0);

    configure(32'hFFFF_FF00, 32'h0A00_0100, 32'h0A00_01FE);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0101, 48'h0000_0000_0001, 2'd1);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0102, 48'h0000_0000_0002, 2'd0);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0103, 48'h0000_0000_0003, 2'd2);
    push_req(acr_pkg::OP_ADD,     32'h0A00_01FE, 48'hFEDC_BA98_7654, 2'd3);
    push_req(acr_pkg::OP_ADD,     32'hC0A8_0001, 48'h8000_0000_0000, 2'd1);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0104, 48'h0000_0000_0004, 2'd2);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0105, 48'h0000_0000_0005, 2'd1);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0106, 48'h0000_0000_0006, 2'd3);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0107, 48'h0000_0000_0007, 2'd1);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0108, 48'h0000_0000_0008, 2'd1);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0103, 48'hFFFF_FFFF_FFFF, 2'd1);
    push_req(acr_pkg::OP_RESOLVE, 32'h0A00_0103, 48'h0, 2'd0);
    push_req(acr_pkg::OP_RESOLVE, 32'h0808_0808, 48'h0, 2'd0);
    push_req(acr_pkg::OP_RESOLVE, 32'h0A00_0199, 48'h0, 2'd0);
    push_req(acr_pkg::OP_ADD,     32'hFFFF_FFFF, 48'h0, 2'd3);
    push_req(acr_pkg::OP_RESOLVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0101, 48'h1234_5678_9ABC, 2'd0);
    push_req(acr_pkg::OP_ADD,     32'h0A00_0109, 48'h0000_0000_0009, 2'd2);
    push_req(acr_pkg::OP_RESOLVE, 32'h0A00_0101, 48'h0, 2'd0);
    for (int n = 0; n < 260; n++)
      push_req(acr_pkg::OP_RESOLVE, 32'h0A00_0103, {16'($urandom), $urandom},
               2'($urandom_range(0, 3)));

    random_prefix_phase(90, 1'b1);
    random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 90, 1'b0);
    random_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 90, 1'b0);
    random_phase(32'h0000_0000, $urandom | 32'h1, $urandom, 90, 1'b0);
    random_prefix_phase(90, 1'b1);

    wait_idle();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", outcome_q.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* arp_cache_resolver_unit.f */
src/acr_pkg.sv
src/acr_ram.sv
src/acr_engine.sv
src/arp_cache_resolver_unit.sv
tb/sv/tb.sv
